/* src/chbf_pkg.sv */
// Shared types and constants for the chained-block byte FIFO.
// Holds command codes, status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chbf_pkg;

    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_WR_BYTE,
        DP_WR_FRESH,
        DP_WR_POOL,
        DP_LOAD_FREE,
        DP_LINK_RD_HEAD,
        DP_GIVE_BACK,
        DP_RD_BYTE,
        DP_CLEAR_END
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic                tail_full;
        logic                free_avail;
        logic                fresh_avail;
        logic                head_exhausted;
        logic                buf_empty;
        logic                chain_more;
        logic [BYTE_W-1:0]   rdata;
        logic [FILL_W-1:0]   fill;
    } t_dp_stat;

endpackage

`default_nettype wire

/* src/chained_block_byte_fifo_unit.sv */
// Top level of the chained-block byte FIFO.
// Instantiates chbf_ctrl and chbf_datapath; depends on chbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Byte FIFO kept as a chain of BLOCK_COUNT blocks of BLOCK_BYTES bytes, with
// returned blocks on a free list. Each request (write, read or clear) yields
// one result carrying the fill level. Requests are handled one at a time; the
// controller steps through registered reads of the byte store and the link
// memory. A write that links a block from the free list adds a step that loads
// the next free-list head; a read that first returns an exhausted head block
// adds a link-memory read and a give-back step; and a clear takes a link read
// and a give-back for each block it returns. A request with the unused mode
// code goes straight to its result. A finished result waits in the output
// register while the next request is processed. A result that cannot enter the
// output register because the output is stalled holds the controller.
// The memories need no clearing after reset.
module chained_block_byte_fifo_unit #(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_COUNT = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [chbf_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [chbf_pkg::BYTE_W-1:0]   i_write_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [chbf_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_read_valid,
    output logic [chbf_pkg::STATUS_W-1:0]      o_status,
    output logic [chbf_pkg::FILL_W-1:0]        o_fill_level
);

    chbf_pkg::t_dp_cmd  w_cmd;
    chbf_pkg::t_dp_stat w_stat;

    chbf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_byte  (o_read_byte),
        .o_read_valid (o_read_valid),
        .o_status     (o_status),
        .o_fill_level (o_fill_level),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    chbf_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_write_byte (i_write_byte),
        .o_stat       (w_stat)
    );

endmodule

`default_nettype wire

/* src/chbf_datapath.sv */
// Datapath of the chained-block byte FIFO: byte store, link memory and pointers.
// Executes one controller command per cycle and reports status flags.
// Depends on chbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chbf_datapath #(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_COUNT = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire chbf_pkg::t_dp_cmd           i_cmd,
    input  wire logic [chbf_pkg::BYTE_W-1:0] i_write_byte,
    output chbf_pkg::t_dp_stat               o_stat
);

    localparam int STORE_BYTES = BLOCK_BYTES * BLOCK_COUNT;
    localparam int BLK_W       = $clog2(BLOCK_COUNT);
    localparam int OFF_W       = $clog2(BLOCK_BYTES + 1);
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int FREE_W      = $clog2(BLOCK_COUNT + 1);

    logic [chbf_pkg::BYTE_W-1:0] r_store [STORE_BYTES];
    logic [BLK_W-1:0]            r_link  [BLOCK_COUNT];

    logic [BLK_W-1:0]            r_head, n_head;
    logic [BLK_W-1:0]            r_tail, n_tail;
    logic [OFF_W-1:0]            r_hoff, n_hoff;
    logic [OFF_W-1:0]            r_toff, n_toff;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [BLK_W-1:0]            r_free_head, n_free_head;
    logic [FREE_W-1:0]           r_free_len, n_free_len;
    logic [FREE_W-1:0]           r_fresh, n_fresh;
    logic [chbf_pkg::BYTE_W-1:0] r_wbyte;
    logic [chbf_pkg::BYTE_W-1:0] r_store_rdata;
    logic [BLK_W-1:0]            r_link_rdata;

    logic [BLK_W-1:0]  w_new_blk;
    logic [ADDR_W-1:0] w_tail_addr;
    logic [ADDR_W-1:0] w_new_addr;
    logic [ADDR_W-1:0] w_head_addr;
    logic              w_st_we;
    logic [ADDR_W-1:0] w_st_waddr;
    logic              w_st_re;
    logic              w_lk_we;
    logic [BLK_W-1:0]  w_lk_waddr;
    logic [BLK_W-1:0]  w_lk_wdata;
    logic              w_lk_re;
    logic [BLK_W-1:0]  w_lk_raddr;

    // A block taken on a tail overflow comes from the free list or, failing that,
    // from the never-used range.
    assign w_new_blk   = (i_cmd.op == chbf_pkg::DP_WR_POOL) ? r_free_head
                                                            : r_fresh[BLK_W-1:0];
    assign w_tail_addr = ADDR_W'(r_tail) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(r_toff);
    assign w_new_addr  = ADDR_W'(w_new_blk) * ADDR_W'(BLOCK_BYTES);
    assign w_head_addr = ADDR_W'(r_head) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(r_hoff);

    assign w_st_we    = (i_cmd.op == chbf_pkg::DP_WR_BYTE) ||
                        (i_cmd.op == chbf_pkg::DP_WR_POOL) ||
                        (i_cmd.op == chbf_pkg::DP_WR_FRESH);
    assign w_st_waddr = (i_cmd.op == chbf_pkg::DP_WR_BYTE) ? w_tail_addr : w_new_addr;
    assign w_st_re    = (i_cmd.op == chbf_pkg::DP_RD_BYTE);

    assign w_lk_we    = (i_cmd.op == chbf_pkg::DP_WR_POOL) ||
                        (i_cmd.op == chbf_pkg::DP_WR_FRESH) ||
                        (i_cmd.op == chbf_pkg::DP_GIVE_BACK);
    assign w_lk_waddr = (i_cmd.op == chbf_pkg::DP_GIVE_BACK) ? r_head : r_tail;
    assign w_lk_wdata = (i_cmd.op == chbf_pkg::DP_GIVE_BACK) ? r_free_head : w_new_blk;
    assign w_lk_re    = (i_cmd.op == chbf_pkg::DP_WR_POOL) ||
                        (i_cmd.op == chbf_pkg::DP_LINK_RD_HEAD);
    assign w_lk_raddr = (i_cmd.op == chbf_pkg::DP_WR_POOL) ? r_free_head : r_head;

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_store[w_st_waddr] <= r_wbyte;
        end
        if (w_st_re) begin
            r_store_rdata <= r_store[w_head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lk_we) begin
            r_link[w_lk_waddr] <= w_lk_wdata;
        end
        if (w_lk_re) begin
            r_link_rdata <= r_link[w_lk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wbyte <= i_write_byte;
        end
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_hoff      = r_hoff;
        n_toff      = r_toff;
        n_count     = r_count;
        n_free_head = r_free_head;
        n_free_len  = r_free_len;
        n_fresh     = r_fresh;
        case (i_cmd.op)
            chbf_pkg::DP_WR_BYTE: begin
                n_toff  = r_toff + OFF_W'(1);
                n_count = r_count + CNT_W'(1);
            end
            chbf_pkg::DP_WR_POOL: begin
                n_tail     = r_free_head;
                n_toff     = OFF_W'(1);
                n_free_len = r_free_len - FREE_W'(1);
                n_count    = r_count + CNT_W'(1);
            end
            chbf_pkg::DP_WR_FRESH: begin
                n_tail  = r_fresh[BLK_W-1:0];
                n_fresh = r_fresh + FREE_W'(1);
                n_toff  = OFF_W'(1);
                n_count = r_count + CNT_W'(1);
            end
            chbf_pkg::DP_LOAD_FREE: begin
                n_free_head = r_link_rdata;
            end
            chbf_pkg::DP_GIVE_BACK: begin
                n_free_head = r_head;
                n_free_len  = r_free_len + FREE_W'(1);
                n_head      = r_link_rdata;
                n_hoff      = '0;
            end
            chbf_pkg::DP_RD_BYTE: begin
                n_hoff = r_hoff + OFF_W'(1);
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            chbf_pkg::DP_CLEAR_END: begin
                n_head  = r_tail;
                n_hoff  = '0;
                n_toff  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_hoff      <= '0;
            r_toff      <= '0;
            r_count     <= '0;
            r_free_head <= '0;
            r_free_len  <= '0;
            r_fresh     <= FREE_W'(1);
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_hoff      <= n_hoff;
            r_toff      <= n_toff;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_free_len  <= n_free_len;
            r_fresh     <= n_fresh;
        end
    end

    assign o_stat.tail_full      = (r_toff == OFF_W'(BLOCK_BYTES));
    assign o_stat.free_avail     = (r_free_len != '0);
    assign o_stat.fresh_avail    = (r_fresh < FREE_W'(BLOCK_COUNT));
    assign o_stat.head_exhausted = (r_head != r_tail) && (r_hoff == OFF_W'(BLOCK_BYTES));
    assign o_stat.buf_empty      = (r_head == r_tail) && (r_hoff >= r_toff);
    assign o_stat.chain_more     = (r_head != r_tail);
    assign o_stat.rdata          = r_store_rdata;
    assign o_stat.fill           = chbf_pkg::FILL_W'(r_count);

`ifndef SYNTHESIS
    // The tail block is never on the free list, so the list is shorter than
    // the number of blocks ever handed out.
    a_free_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_len < r_fresh)
        else $error("free list longer than the blocks in use");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_BYTES))
        else $error("byte count beyond store size");

    a_give_back_not_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == chbf_pkg::DP_GIVE_BACK) |-> (r_head != r_tail))
        else $error("tail block returned to the free list");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == chbf_pkg::DP_WR_BYTE) |-> (r_toff < OFF_W'(BLOCK_BYTES)))
        else $error("byte written past the end of the tail block");
`endif

endmodule

`default_nettype wire

/* src/chbf_ctrl.sv */
// Controller of the chained-block byte FIFO: request handshake, command
// sequencing and the result register. Depends on chbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chbf_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [chbf_pkg::MODE_W-1:0]   i_mode,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [chbf_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_read_valid,
    output logic [chbf_pkg::STATUS_W-1:0]      o_status,
    output logic [chbf_pkg::FILL_W-1:0]        o_fill_level,
    output chbf_pkg::t_dp_cmd                  o_cmd,
    input  wire chbf_pkg::t_dp_stat            i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WR_LINK,
        S_RD_LINK,
        S_RD_CHECK,
        S_CLR_CHECK,
        S_CLR_LINK,
        S_RESULT
    } t_state;

    t_state                        r_state, n_state;
    logic [chbf_pkg::MODE_W-1:0]   r_mode;
    logic [chbf_pkg::STATUS_W-1:0] r_pend_status, n_pend_status;
    logic                          r_pend_rvalid, n_pend_rvalid;
    logic                          r_out_valid;
    logic                          w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        n_pend_status = r_pend_status;
        n_pend_rvalid = r_pend_rvalid;
        o_cmd.load    = 1'b0;
        o_cmd.op      = chbf_pkg::DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    n_pend_status = chbf_pkg::ST_OK;
                    n_pend_rvalid = 1'b0;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_mode)
                    chbf_pkg::MODE_WRITE: begin
                        n_state = S_RESULT;
                        if (!i_stat.tail_full) begin
                            o_cmd.op = chbf_pkg::DP_WR_BYTE;
                        end else if (i_stat.free_avail) begin
                            // The successor on the free list is read from the link memory and loaded in S_WR_LINK.
                            o_cmd.op = chbf_pkg::DP_WR_POOL;
                            n_state  = S_WR_LINK;
                        end else if (i_stat.fresh_avail) begin
                            o_cmd.op = chbf_pkg::DP_WR_FRESH;
                        end else begin
                            n_pend_status = chbf_pkg::ST_FULL;
                        end
                    end
                    chbf_pkg::MODE_READ: begin
                        if (i_stat.head_exhausted) begin
                            o_cmd.op = chbf_pkg::DP_LINK_RD_HEAD;
                            n_state  = S_RD_LINK;
                        end else begin
                            n_state = S_RD_CHECK;
                        end
                    end
                    chbf_pkg::MODE_CLEAR: begin
                        n_state = S_CLR_CHECK;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_WR_LINK: begin
                o_cmd.op = chbf_pkg::DP_LOAD_FREE;
                n_state  = S_RESULT;
            end
            S_RD_LINK: begin
                o_cmd.op = chbf_pkg::DP_GIVE_BACK;
                n_state  = S_RD_CHECK;
            end
            S_RD_CHECK: begin
                n_state = S_RESULT;
                if (i_stat.buf_empty) begin
                    n_pend_status = chbf_pkg::ST_EMPTY;
                end else begin
                    o_cmd.op      = chbf_pkg::DP_RD_BYTE;
                    n_pend_rvalid = 1'b1;
                end
            end
            S_CLR_CHECK: begin
                if (i_stat.chain_more) begin
                    o_cmd.op = chbf_pkg::DP_LINK_RD_HEAD;
                    n_state  = S_CLR_LINK;
                end else begin
                    o_cmd.op = chbf_pkg::DP_CLEAR_END;
                    n_state  = S_RESULT;
                end
            end
            S_CLR_LINK: begin
                o_cmd.op = chbf_pkg::DP_GIVE_BACK;
                n_state  = S_CLR_CHECK;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_pend_status <= chbf_pkg::ST_OK;
            r_pend_rvalid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pend_status <= n_pend_status;
            r_pend_rvalid <= n_pend_rvalid;
            if (r_state == S_IDLE && i_valid) begin
                r_mode <= i_mode;
            end
            // The store read data register still holds the byte fetched by the
            // previous state, since nothing reads the store in the result state.
            if (r_state == S_RESULT && w_out_free) begin
                r_out_valid  <= 1'b1;
                o_read_byte  <= r_pend_rvalid ? i_stat.rdata : '0;
                o_read_valid <= r_pend_rvalid;
                o_status     <= r_pend_status;
                o_fill_level <= i_stat.fill;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_rvalid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |-> (o_status == chbf_pkg::ST_OK))
        else $error("read byte delivered with an error status");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && w_out_free) |=> o_valid)
        else $error("finished request left no result");
`endif

endmodule

`default_nettype wire

/* sim/chained_block_byte_fifo_unit_test.sv */
// Self-checking regression for the chained-block byte FIFO top level.
// Drives write, read and clear requests and checks every result against a predictor.
// Depends on chbf_pkg and chained_block_byte_fifo_unit.
`timescale 1ns / 1ps

module chained_block_byte_fifo_unit_test;

    localparam int BYTE_W         = chbf_pkg::BYTE_W;
    localparam int MODE_W         = chbf_pkg::MODE_W;
    localparam int STATUS_W       = chbf_pkg::STATUS_W;
    localparam int FILL_W         = chbf_pkg::FILL_W;
    localparam int BLOCK_BYTES    = 64;
    localparam int BLOCK_COUNT    = 16;
    localparam int POOL_BYTES     = BLOCK_BYTES * BLOCK_COUNT;
    localparam int BLK_W          = $clog2(BLOCK_COUNT);
    localparam int OFF_W          = $clog2(BLOCK_BYTES) + 1;
    localparam int LIST_W         = $clog2(BLOCK_COUNT) + 1;
    localparam int RANDOM_ITEMS   = 780;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;

    // The block ignores the one mode code that the package leaves unnamed.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
    } t_fifo_request;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic                read_valid;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_level;
    } t_fifo_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [MODE_W-1:0]   i_mode = chbf_pkg::MODE_WRITE;
    logic [BYTE_W-1:0]   i_write_byte = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [BYTE_W-1:0]   o_read_byte;
    logic                o_read_valid;
    logic [STATUS_W-1:0] o_status;
    logic [FILL_W-1:0]   o_fill_level;

    t_fifo_request pending_requests[$];
    t_fifo_answer  expected_answers[$];
    t_fifo_request next_request;
    t_fifo_answer  oldest_answer;
    int unsigned   n_total = 0;
    int unsigned   n_sent = 0;
    int unsigned   fail_count = 0;
    int unsigned   quiet_cycles = 0;

    // Shadow copy of the buffer state.
    logic [BYTE_W-1:0] shadow_bytes [POOL_BYTES];
    logic [BLK_W-1:0]  shadow_links [BLOCK_COUNT];
    logic [BLK_W-1:0]  head_blk = '0;
    logic [BLK_W-1:0]  tail_blk = '0;
    logic [BLK_W-1:0]  free_top = '0;
    logic [OFF_W-1:0]  head_off = '0;
    logic [OFF_W-1:0]  tail_off = '0;
    logic [FILL_W-1:0] level = '0;
    logic [LIST_W-1:0] free_len = '0;
    logic [LIST_W-1:0] fresh_blk = LIST_W'(1);

    chained_block_byte_fifo_unit #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_write_byte (i_write_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_byte  (o_read_byte),
        .o_read_valid (o_read_valid),
        .o_status     (o_status),
        .o_fill_level (o_fill_level)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // The head block goes onto the free list and its successor becomes the head.
    task automatic release_head_block();
        logic [BLK_W-1:0] succ;
        succ = shadow_links[head_blk];
        shadow_links[head_blk] = free_top;
        free_top = head_blk;
        free_len = free_len + 1'b1;
        head_blk = succ;
        head_off = '0;
    endtask

    task automatic predict_answer(input logic [MODE_W-1:0] mode,
                                  input logic [BYTE_W-1:0] data);
        t_fifo_answer     ans;
        logic [BLK_W-1:0] new_blk;
        logic             room;
        ans = '0;
        new_blk = '0;
        room = 1'b1;
        case (mode)
            chbf_pkg::MODE_WRITE: begin
                if (tail_off >= OFF_W'(BLOCK_BYTES)) begin
                    if (free_len != 0) begin
                        new_blk = free_top;
                        free_top = shadow_links[new_blk];
                        free_len = free_len - 1'b1;
                    end else if (fresh_blk < LIST_W'(BLOCK_COUNT)) begin
                        new_blk = fresh_blk[BLK_W-1:0];
                        fresh_blk = fresh_blk + 1'b1;
                    end else begin
                        room = 1'b0;
                    end
                    if (room) begin
                        shadow_links[tail_blk] = new_blk;
                        tail_blk = new_blk;
                        tail_off = '0;
                    end
                end
                if (room) begin
                    shadow_bytes[int'(tail_blk) * BLOCK_BYTES + int'(tail_off)] = data;
                    tail_off = tail_off + 1'b1;
                    level = level + 1'b1;
                end else begin
                    ans.status = chbf_pkg::ST_FULL;
                end
            end
            chbf_pkg::MODE_READ: begin
                if (head_blk != tail_blk && head_off >= OFF_W'(BLOCK_BYTES)) begin
                    release_head_block();
                end
                if (head_blk == tail_blk && head_off >= tail_off) begin
                    ans.status = chbf_pkg::ST_EMPTY;
                end else begin
                    ans.read_byte =
                        shadow_bytes[int'(head_blk) * BLOCK_BYTES + int'(head_off)];
                    ans.read_valid = 1'b1;
                    head_off = head_off + 1'b1;
                    level = level - 1'b1;
                end
            end
            chbf_pkg::MODE_CLEAR: begin
                while (head_blk != tail_blk) begin
                    release_head_block();
                end
                head_off = '0;
                tail_off = '0;
                level = '0;
            end
            default: begin
            end
        endcase
        ans.fill_level = level;
        expected_answers.push_back(ans);
    endtask

    function automatic int unsigned sender_idle_pct();
        case ((n_sent * 3) / n_total)
            0: return 11;
            1: return 57;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_idle_pct();
        case ((n_sent * 3) / n_total)
            0: return 57;
            1: return 11;
            default: return 0;
        endcase
    endfunction

    // Request driver: advances only when the current request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_answer(i_mode, i_write_byte);
                n_sent = n_sent + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    next_request = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= next_request.mode;
                    i_write_byte <= next_request.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result: read_byte %0h status %0d fill_level %0d",
                           o_read_byte, o_status, o_fill_level);
                    fail_count = fail_count + 1;
                end else begin
                    oldest_answer = expected_answers.pop_front();
                    if (o_read_byte !== oldest_answer.read_byte) begin
                        $error("read_byte: expected %0h, got %0h",
                               oldest_answer.read_byte, o_read_byte);
                        fail_count = fail_count + 1;
                    end
                    if (o_read_valid !== oldest_answer.read_valid) begin
                        $error("read_valid: expected %0d, got %0d",
                               oldest_answer.read_valid, o_read_valid);
                        fail_count = fail_count + 1;
                    end
                    if (o_status !== oldest_answer.status) begin
                        $error("status: expected %0d, got %0d", oldest_answer.status, o_status);
                        fail_count = fail_count + 1;
                    end
                    if (o_fill_level !== oldest_answer.fill_level) begin
                        $error("fill_level: expected %0d, got %0d",
                               oldest_answer.fill_level, o_fill_level);
                        fail_count = fail_count + 1;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < receiver_idle_pct());
        end
    end

    // Watchdog on cycles in which neither side moves anything.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("chained_block_byte_fifo_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [MODE_W-1:0] mode,
                                input logic [BYTE_W-1:0] data);
        pending_requests.push_back('{mode: mode, data: data});
    endtask

    initial begin : stimulus
        int unsigned n_random;
        int unsigned burst;
        int unsigned pick;
        int unsigned k;
        logic [MODE_W-1:0] mode;

        // Directed opening: empty read, clear and ignored mode on an empty buffer,
        // byte extremes, draining to empty, and clear with data held.
        push_request(chbf_pkg::MODE_READ, 8'h00);
        push_request(chbf_pkg::MODE_CLEAR, 8'hFF);
        push_request(MODE_UNUSED, 8'hFF);
        push_request(chbf_pkg::MODE_WRITE, 8'h00);
        push_request(chbf_pkg::MODE_WRITE, 8'hFF);
        push_request(chbf_pkg::MODE_WRITE, 8'h5A);
        push_request(MODE_UNUSED, 8'h00);
        push_request(chbf_pkg::MODE_READ, 8'hFF);
        push_request(chbf_pkg::MODE_READ, 8'h00);
        push_request(chbf_pkg::MODE_READ, 8'hA5);
        push_request(chbf_pkg::MODE_READ, 8'h00);
        push_request(chbf_pkg::MODE_WRITE, 8'hA5);
        push_request(chbf_pkg::MODE_WRITE, 8'h3C);
        push_request(chbf_pkg::MODE_CLEAR, 8'h00);
        push_request(chbf_pkg::MODE_READ, 8'h00);
        push_request(chbf_pkg::MODE_WRITE, 8'h81);
        push_request(chbf_pkg::MODE_READ, 8'h7E);

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            pick = $urandom_range(9);
            if (pick <= 3) begin
                burst = $urandom_range(1, 150);
                for (k = 0; k < burst; k++) begin
                    push_request(chbf_pkg::MODE_WRITE, BYTE_W'($urandom_range(255)));
                end
                n_random += burst;
            end else if (pick <= 6) begin
                burst = $urandom_range(1, 150);
                for (k = 0; k < burst; k++) begin
                    push_request(chbf_pkg::MODE_READ, BYTE_W'($urandom_range(255)));
                end
                n_random += burst;
            end else if (pick == 7) begin
                burst = $urandom_range(1, 40);
                for (k = 0; k < burst; k++) begin
                    pick = $urandom_range(15);
                    if (pick < 7) begin
                        mode = chbf_pkg::MODE_WRITE;
                    end else if (pick < 14) begin
                        mode = chbf_pkg::MODE_READ;
                    end else if (pick == 14) begin
                        mode = chbf_pkg::MODE_CLEAR;
                    end else begin
                        mode = MODE_UNUSED;
                    end
                    push_request(mode, BYTE_W'($urandom_range(255)));
                    if (mode != MODE_UNUSED) begin
                        n_random++;
                    end
                end
            end else if (pick == 8) begin
                push_request(chbf_pkg::MODE_CLEAR, BYTE_W'($urandom_range(255)));
                n_random++;
            end else begin
                push_request(MODE_UNUSED, BYTE_W'($urandom_range(255)));
            end
        end
        n_total = pending_requests.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total) begin
            @(posedge i_clk);
        end
        while (expected_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("chained_block_byte_fifo_unit regression: pass");
        end else begin
            $display("chained_block_byte_fifo_unit regression: fail");
        end
        $finish;
    end

endmodule
